// ===== rtl/prrq_pkg.sv =====
// Package: shared constants and codes of the priority round-robin ready queue.
`timescale 1ns / 1ps
`default_nettype none
package prrq_pkg;
    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_NUM_LEVELS = 8;

    localparam int FUNC_W = 2;
    localparam int SLOT_W = 4;
    localparam int PRIO_W = 3;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PREEMPT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_PICK    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IDLE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERROR  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_REJECT = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/prrq_if.sv =====
// Interfaces: request and response channels of the ready queue.
`timescale 1ns / 1ps
`default_nettype none
interface prrq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] slot;
    logic [2:0] priority_req;
    modport source (output valid, output func, output slot, output priority_req, input ready);
    modport sink (input valid, input func, input slot, input priority_req, output ready);
endinterface

interface prrq_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] next_slot;
    logic [1:0] status_code;
    logic       switch_needed;
    modport source (output valid, output next_slot, output status_code, output switch_needed,
                    input ready);
    modport sink (input valid, input next_slot, input status_code, input switch_needed,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/prrq_ram.sv =====
// Generic RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module prrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/priority_round_robin_ready_queue.sv =====
// Top level: multilevel priority round-robin ready queue over linked task slots.
// Steps per request: insert APP, remove UNL, pick PICK, preempt UNL/APP/PICK as needed, then
// FIN; rejects and stray removes go straight to FIN, which waits while the response stalls.
// Throughput: one word at a time; the sequencer over the link RAMs sets the rate.
// A new request word is taken while a finished response still waits.
// Reset clears queued and non-empty flags; link RAMs and heads/tails need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module priority_round_robin_ready_queue #(
    parameter int NUM_SLOTS  = prrq_pkg::DEF_NUM_SLOTS,
    parameter int NUM_LEVELS = prrq_pkg::DEF_NUM_LEVELS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    prrq_req_if.sink   i_req,
    prrq_rsp_if.source o_rsp
);
    import prrq_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam logic [LW-1:0] LAST_LV = LW'(NUM_LEVELS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UNL  = 3'd1;
    localparam logic [2:0] S_APP  = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state;
    logic [FUNC_W-1:0] r_func;
    logic [SLOT_W-1:0] r_slot;
    logic [SW-1:0]     r_sidx;
    logic              r_in_range;
    logic [LW-1:0]     r_lv;

    logic [LW-1:0]     r_level [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_queued;
    logic [SW-1:0]     r_head [NUM_LEVELS];
    logic [SW-1:0]     r_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] r_nonempty;

    logic [SLOT_W-1:0] r_res_slot;
    logic [STAT_W-1:0] r_res_stat;
    logic              r_res_sw;

    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [STAT_W-1:0] r_out_stat;
    logic              r_out_sw;

    logic              accept;
    logic [SW-1:0]     in_sidx;
    logic              in_range;
    logic [LW-1:0]     in_lv_sat;
    logic [LW-1:0]     in_lv_cur;
    logic [LW-1:0]     lvl_s;
    logic [LW-1:0]     lvl_s_sat;

    logic              nx_we, pv_we;
    logic [SW-1:0]     nx_waddr, pv_waddr, nx_wdata, pv_wdata, raddr;
    logic [SW-1:0]     rd_next, rd_prev;

    logic              pk_found;
    logic [SW-1:0]     pk_head;
    logic              unl_head, unl_tail;
    logic              out_free;

    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign in_sidx   = SW'(i_req.slot);
    assign in_range  = (32'(i_req.slot) < NUM_SLOTS);
    assign in_lv_sat = (32'(i_req.priority_req) >= NUM_LEVELS) ? LAST_LV
                                                               : LW'(i_req.priority_req);
    assign in_lv_cur = (32'(r_level[in_sidx]) >= NUM_LEVELS) ? LAST_LV : r_level[in_sidx];
    assign lvl_s     = r_level[r_sidx];
    assign lvl_s_sat = (32'(lvl_s) >= NUM_LEVELS) ? LAST_LV : lvl_s;
    assign raddr     = in_sidx;
    assign unl_head  = (r_head[lvl_s_sat] == r_sidx);
    assign unl_tail  = (r_tail[lvl_s_sat] == r_sidx);
    assign out_free  = !r_out_valid || o_rsp.ready;

    prrq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(raddr), .o_rdata(rd_next)
    );
    prrq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_prev_ram (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(raddr), .o_rdata(rd_prev)
    );

    always_comb begin
        pk_found = 1'b0;
        pk_head  = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_nonempty[l]) begin
                pk_found = 1'b1;
                pk_head  = r_head[l];
            end
        end
    end

    always_comb begin
        nx_we = 1'b0; nx_waddr = rd_prev; nx_wdata = rd_next;
        pv_we = 1'b0; pv_waddr = rd_next; pv_wdata = rd_prev;
        case (r_state)
            S_UNL: begin
                if (!unl_head) begin
                    nx_we = 1'b1;
                    pv_we = !unl_tail;
                end
            end
            S_APP: begin
                nx_waddr = r_tail[r_lv];
                nx_wdata = r_sidx;
                pv_waddr = r_sidx;
                pv_wdata = r_tail[r_lv];
                nx_we    = r_nonempty[r_lv];
                pv_we    = r_nonempty[r_lv];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_queued    <= '0;
            r_nonempty  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func     <= i_req.func;
                        r_slot     <= i_req.slot;
                        r_sidx     <= in_sidx;
                        r_in_range <= in_range;
                        r_res_slot <= '0;
                        r_res_stat <= STAT_DONE;
                        r_res_sw   <= 1'b0;
                        case (i_req.func)
                            FUNC_INSERT: begin
                                r_lv <= in_lv_sat;
                                if (!in_range || r_queued[in_sidx]) begin
                                    r_res_stat <= STAT_REJECT;
                                    r_state    <= S_FIN;
                                end else begin
                                    r_state <= S_APP;
                                end
                            end
                            FUNC_REMOVE: begin
                                r_state <= (in_range && r_queued[in_sidx]) ? S_UNL : S_FIN;
                            end
                            FUNC_PREEMPT: begin
                                r_lv <= in_lv_cur;
                                if (!in_range) begin
                                    r_state <= S_PICK;
                                end else if (r_queued[in_sidx]) begin
                                    r_state <= S_UNL;
                                end else begin
                                    r_state <= S_APP;
                                end
                            end
                            default: begin
                                r_state <= S_PICK;
                            end
                        endcase
                    end
                end
                S_UNL: begin
                    r_lv <= lvl_s_sat;
                    if (unl_head && unl_tail) begin
                        r_nonempty[lvl_s_sat] <= 1'b0;
                    end else if (unl_head) begin
                        r_head[lvl_s_sat] <= rd_next;
                    end else if (unl_tail) begin
                        r_tail[lvl_s_sat] <= rd_prev;
                    end
                    r_queued[r_sidx] <= 1'b0;
                    r_state <= (r_func == FUNC_REMOVE) ? S_FIN : S_APP;
                end
                S_APP: begin
                    if (!r_nonempty[r_lv]) begin
                        r_head[r_lv]     <= r_sidx;
                        r_nonempty[r_lv] <= 1'b1;
                    end
                    r_tail[r_lv]     <= r_sidx;
                    r_level[r_sidx]  <= r_lv;
                    r_queued[r_sidx] <= 1'b1;
                    r_state <= (r_func == FUNC_INSERT) ? S_FIN : S_PICK;
                end
                S_PICK: begin
                    if (pk_found) begin
                        r_res_slot <= SLOT_W'(pk_head);
                        r_res_stat <= STAT_DONE;
                        r_res_sw   <= (32'(pk_head) != 32'(r_slot));
                    end else if (r_in_range && lvl_s == LAST_LV) begin
                        r_res_slot <= r_slot;
                        r_res_stat <= STAT_IDLE;
                    end else begin
                        r_res_slot <= '0;
                        r_res_stat <= STAT_ERROR;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_slot  <= r_res_slot;
                        r_out_stat  <= r_res_stat;
                        r_out_sw    <= r_res_sw;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.next_slot     = r_out_slot;
    assign o_rsp.status_code   = r_out_stat;
    assign o_rsp.switch_needed = r_out_sw;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status_code == STAT_ERROR)
            |-> (o_rsp.next_slot == '0 && !o_rsp.switch_needed))
        else $error("error response carries a slot");
    a_idle_nosw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status_code == STAT_IDLE) |-> !o_rsp.switch_needed)
        else $error("idle keep asks for a switch");
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_nonempty == '0 && r_queued == '0 && !o_rsp.valid))
        else $error("reset left queue state");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench: directed and randomized ready-queue operations checked against an in-bench scheduler model.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import prrq_pkg::*;

    localparam int NS = DEF_NUM_SLOTS;
    localparam int NL = DEF_NUM_LEVELS;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
    } sched_op_t;

    typedef struct packed {
        logic [SLOT_W-1:0] next_slot;
        logic [STAT_W-1:0] status;
        logic              sw;
    } sched_rsp_t;

    logic i_clk;
    logic i_rst_n;

    prrq_req_if req ();
    prrq_rsp_if rsp ();

    priority_round_robin_ready_queue DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req.sink),
        .o_rsp  (rsp.source)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // scheduler model state
    logic [PRIO_W-1:0] slot_level[NS];
    logic              slot_linked[NS];
    logic              slot_known[NS];
    logic [SLOT_W-1:0] link_next[NS];
    logic [SLOT_W-1:0] link_prev[NS];
    logic [SLOT_W-1:0] lvl_head[NL];
    logic [SLOT_W-1:0] lvl_tail[NL];
    logic              lvl_busy[NL];

    sched_op_t  pending_ops[$];
    sched_rsp_t expected_rsps[$];

    int errors = 0;
    int n_ops = 0, n_picks = 0, n_idle = 0, n_err = 0, n_rej = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    bit op_taken;

    task automatic report(input string what, input sched_rsp_t got, input sched_rsp_t want);
        $display("MISMATCH %s: got next=%0d stat=%0d sw=%0d, want next=%0d stat=%0d sw=%0d",
                 what, got.next_slot, got.status, got.sw,
                 want.next_slot, want.status, want.sw);
        errors++;
    endtask

    function automatic void enqueue_slot(input int s, input int lv);
        if (lvl_busy[lv]) begin
            link_next[lvl_tail[lv]] = SLOT_W'(s);
            link_prev[s] = lvl_tail[lv];
        end else begin
            lvl_head[lv] = SLOT_W'(s);
            lvl_busy[lv] = 1'b1;
        end
        lvl_tail[lv] = SLOT_W'(s);
        slot_level[s] = PRIO_W'(lv);
        slot_linked[s] = 1'b1;
        slot_known[s] = 1'b1;
    endfunction

    function automatic void dequeue_slot(input int s);
        int lv;
        logic hd;
        logic tl;
        lv = int'(slot_level[s]);
        hd = (int'(lvl_head[lv]) == s);
        tl = (int'(lvl_tail[lv]) == s);
        if (hd && tl) begin
            lvl_busy[lv] = 1'b0;
        end else if (hd) begin
            lvl_head[lv] = link_next[s];
        end else if (tl) begin
            lvl_tail[lv] = link_prev[s];
            link_next[link_prev[s]] = link_next[s];
        end else begin
            link_next[link_prev[s]] = link_next[s];
            link_prev[link_next[s]] = link_prev[s];
        end
        slot_linked[s] = 1'b0;
    endfunction

    function automatic sched_rsp_t model_pick(input int cur);
        sched_rsp_t r;
        r = '0;
        for (int lv = 0; lv < NL; lv++) begin
            if (lvl_busy[lv]) begin
                r.next_slot = lvl_head[lv];
                r.status = STAT_DONE;
                r.sw = (int'(lvl_head[lv]) != cur);
                return r;
            end
        end
        if (int'(slot_level[cur]) == NL - 1) begin
            r.next_slot = SLOT_W'(cur);
            r.status = STAT_IDLE;
        end else begin
            r.status = STAT_ERROR;
        end
        return r;
    endfunction

    function automatic bit any_queued();
        for (int lv = 0; lv < NL; lv++) if (lvl_busy[lv]) return 1'b1;
        return 1'b0;
    endfunction

    // apply one operation to the model and queue the word it should return
    function automatic void schedule_op(input sched_op_t op);
        sched_rsp_t r;
        int lv;
        r = '0;
        case (op.func)
            FUNC_INSERT: begin
                if (slot_linked[op.slot]) r.status = STAT_REJECT;
                else enqueue_slot(int'(op.slot), int'(op.prio));
            end
            FUNC_REMOVE: begin
                if (slot_linked[op.slot]) dequeue_slot(int'(op.slot));
            end
            FUNC_PREEMPT: begin
                lv = int'(slot_level[op.slot]);
                if (slot_linked[op.slot]) dequeue_slot(int'(op.slot));
                enqueue_slot(int'(op.slot), lv);
                r = model_pick(int'(op.slot));
            end
            default: r = model_pick(int'(op.slot));
        endcase
        n_ops++;
        if (op.func inside {FUNC_PICK, FUNC_PREEMPT}) n_picks++;
        if (r.status == STAT_IDLE) n_idle++;
        if (r.status == STAT_ERROR) n_err++;
        if (r.status == STAT_REJECT) n_rej++;
        pending_ops.push_back(op);
        expected_rsps.push_back(r);
    endfunction

    function automatic void push_op(input logic [FUNC_W-1:0] f, input int s, input int p);
        sched_op_t op;
        op.func = f;
        op.slot = SLOT_W'(s);
        op.prio = PRIO_W'(p);
        schedule_op(op);
    endfunction

    function automatic int pick_slot(input int want_linked, input bit need_known);
        int s;
        for (int k = 0; k < 40; k++) begin
            s = $urandom_range(NS - 1);
            if (need_known && !slot_known[s]) continue;
            if (want_linked < 0 || slot_linked[s] == want_linked) return s;
        end
        return -1;
    endfunction

    // mostly well-formed scheduling traffic; some rejected inserts and stray removes
    function automatic void random_op();
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 35) begin
            s = pick_slot(r < 32 ? 0 : 1, 1'b0);
            if (s < 0) s = $urandom_range(NS - 1);
            push_op(FUNC_INSERT, s, $urandom_range(NL - 1));
        end else if (r < 60) begin
            s = pick_slot(r < 56 ? 1 : 0, 1'b0);
            if (s < 0) s = $urandom_range(NS - 1);
            push_op(FUNC_REMOVE, s, $urandom_range(NL - 1));
        end else begin
            s = pick_slot(-1, !any_queued() || r < 80);
            if (s < 0) begin
                push_op(FUNC_INSERT, $urandom_range(NS - 1), $urandom_range(NL - 1));
            end else begin
                push_op(r < 80 ? FUNC_PREEMPT : FUNC_PICK, s, $urandom_range(NL - 1));
            end
        end
    endfunction

    // request driver
    always @(posedge i_clk) op_taken = req.valid && req.ready;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
        end else begin
            if (op_taken) void'(pending_ops.pop_front());
            if (req.valid && !op_taken) begin
                req.valid <= 1'b1;
            end else if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req.valid <= 1'b1;
                req.func <= pending_ops[0].func;
                req.slot <= pending_ops[0].slot;
                req.priority_req <= pending_ops[0].prio;
            end else begin
                req.valid <= 1'b0;
                req.func <= FUNC_W'($urandom);
                req.slot <= SLOT_W'($urandom);
                req.priority_req <= PRIO_W'($urandom);
            end
        end
    end

    // response ready and long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            rsp.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // response checker
    always @(posedge i_clk) begin
        sched_rsp_t got;
        sched_rsp_t want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got.next_slot = rsp.next_slot;
            got.status = rsp.status_code;
            got.sw = rsp.switch_needed;
            if (expected_rsps.size() == 0) begin
                want = '0;
                report("unexpected word", got, want);
            end else begin
                want = expected_rsps.pop_front();
                if (got.status != want.status) report("status_code", got, want);
                else if (got.next_slot != want.next_slot) report("next_slot", got, want);
                else if (got.sw != want.sw) report("switch_needed", got, want);
            end
        end
    end

    task automatic drain();
        while (expected_rsps.size() > 0 || pending_ops.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) random_op();
        drain();
    endtask

    initial begin
        req.valid = 1'b0;
        req.func = FUNC_INSERT;
        req.slot = '0;
        req.priority_req = '0;
        rsp.ready = 1'b0;
        i_rst_n = 1'b0;
        for (int s = 0; s < NS; s++) begin
            slot_linked[s] = 1'b0;
            slot_known[s] = 1'b0;
            slot_level[s] = '0;
            link_next[s] = '0;
            link_prev[s] = '0;
        end
        for (int lv = 0; lv < NL; lv++) begin
            lvl_busy[lv] = 1'b0;
            lvl_head[lv] = '0;
            lvl_tail[lv] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rejects, rotation, idle keep, error, unlink from head/middle/tail
        push_op(FUNC_INSERT, 0, 0);
        push_op(FUNC_INSERT, 15, 7);
        push_op(FUNC_INSERT, 0, 3);
        push_op(FUNC_INSERT, 5, 0);
        push_op(FUNC_PICK, 0, 0);
        push_op(FUNC_PREEMPT, 0, 0);
        push_op(FUNC_REMOVE, 5, 0);
        push_op(FUNC_REMOVE, 0, 0);
        push_op(FUNC_REMOVE, 0, 0);
        push_op(FUNC_PICK, 15, 0);
        push_op(FUNC_REMOVE, 15, 7);
        push_op(FUNC_PICK, 15, 0);
        push_op(FUNC_PICK, 0, 7);
        push_op(FUNC_PREEMPT, 0, 0);
        push_op(FUNC_PREEMPT, 15, 0);
        push_op(FUNC_REMOVE, 0, 0);
        push_op(FUNC_REMOVE, 15, 0);
        push_op(FUNC_INSERT, 3, 3);
        push_op(FUNC_INSERT, 9, 3);
        push_op(FUNC_INSERT, 12, 3);
        push_op(FUNC_REMOVE, 9, 0);
        push_op(FUNC_REMOVE, 12, 0);
        push_op(FUNC_REMOVE, 3, 0);
        drain();

        run_phase(250, 0, 0);
        run_phase(200, 84, 0);
        run_phase(200, 0, 84);
        run_phase(200, 20, 20);

        // receiver holds off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 10;
        hold_cycles = 300;
        for (int i = 0; i < 100; i++) random_op();
        drain();

        run_phase(200, 0, 0);

        $display("Covered %0d operations: %0d picks/preempts, %0d idle keeps,",
                 n_ops, n_picks, n_idle);
        $display("  %0d errors, %0d rejects; phases: no idling, sender idle, receiver stall, both",
                 n_err, n_rej);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d words outstanding", expected_rsps.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
